FILE: sv/pwm_pkg.sv
// Package for the phonetic word matcher: widths, status codes, state record
// and the sound-alike character folding. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pwm_pkg;

    localparam int MAX_WORD_CHARS = 8;
    localparam int POSITION_BITS  = 16;
    localparam int CHAR_BITS      = 8;
    localparam int COUNT_BITS     = $clog2(MAX_WORD_CHARS + 1);
    localparam int SEL_BITS       = (MAX_WORD_CHARS > 1) ? $clog2(MAX_WORD_CHARS) : 1;
    localparam int SEARCH_BITS    = 64;
    localparam int LENGTH_BITS    = 4;
    localparam int STATUS_BITS    = 2;
    localparam int START_BITS     = 16;
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = 24;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_ADDR_BITS  = 1;

    localparam logic [CHAR_BITS-1:0] SPACE_CHAR = 8'h20;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_SEARCH_CHARS  = 1'b0,
        REG_SEARCH_LENGTH = 1'b1
    } t_cfg_reg;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_FOUND     = 2'd0,
        ST_PREFIX    = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        logic [POSITION_BITS-1:0] char_pos;
        logic [POSITION_BITS-1:0] word_start;
        logic [COUNT_BITS-1:0]    matched;
        logic                     all_matched;
        logic                     full_pending;
        logic                     prefix_seen;
        logic                     found;
    } t_scan_state;

    localparam t_scan_state SCAN_RESET = '{
        char_pos:     '0,
        word_start:   '0,
        matched:      '0,
        all_matched:  1'b1,
        full_pending: 1'b0,
        prefix_seen:  1'b0,
        found:        1'b0
    };

    function automatic logic [CHAR_BITS-1:0] canon(input logic [CHAR_BITS-1:0] c);
        logic [CHAR_BITS-1:0] l;
        logic [CHAR_BITS-1:0] r;
        l = c;
        if (c >= "A" && c <= "Z") begin
            l = c + 8'h20;
        end
        case (l)
            "w":     r = "v";
            "j":     r = "g";
            "z":     r = "s";
            "t":     r = "d";
            "u":     r = "o";
            "y":     r = "i";
            "f":     r = "b";
            "p":     r = "b";
            "k":     r = "c";
            "q":     r = "c";
            default: r = l;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/pwm_step.sv
// Next-state and result logic for one text character.
// Depends on pwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwm_step (
    input  wire pwm_pkg::t_scan_state                  i_state,
    input  wire [pwm_pkg::SEARCH_BITS-1:0]             i_search_chars,
    input  wire [pwm_pkg::LENGTH_BITS-1:0]             i_search_length,
    input  wire [pwm_pkg::CHAR_BITS-1:0]               i_char,
    input  wire                                        i_last,
    output pwm_pkg::t_scan_state                       o_state,
    output logic                                       o_res_valid,
    output logic [pwm_pkg::STATUS_BITS-1:0]            o_status,
    output logic [pwm_pkg::START_BITS-1:0]             o_word_start
);
    import pwm_pkg::*;

    logic [COUNT_BITS-1:0]    used_len;
    logic [POSITION_BITS-1:0] next_pos;
    logic [CHAR_BITS-1:0]     want;
    t_scan_state              s;

    always_comb begin
        if (i_search_length == '0) begin
            used_len = COUNT_BITS'(1);
        end else if (32'(i_search_length) > MAX_WORD_CHARS) begin
            used_len = COUNT_BITS'(MAX_WORD_CHARS);
        end else begin
            used_len = COUNT_BITS'(i_search_length);
        end
    end

    assign next_pos = (i_state.char_pos == POS_MAX) ? POS_MAX : i_state.char_pos + 1'b1;
    assign want     = i_search_chars[CHAR_BITS * i_state.matched[SEL_BITS-1:0] +: CHAR_BITS];

    always_comb begin
        s            = i_state;
        o_res_valid  = 1'b0;
        o_status     = ST_NOT_FOUND;
        o_word_start = '0;
        if (!i_state.found) begin
            if (i_char == SPACE_CHAR) begin
                if (i_state.full_pending) begin
                    o_res_valid  = 1'b1;
                    o_status     = ST_FOUND;
                    o_word_start = START_BITS'(i_state.word_start);
                    s.found      = 1'b1;
                end
                s.word_start   = next_pos;
                s.matched      = '0;
                s.all_matched  = 1'b1;
                s.full_pending = 1'b0;
            end else if (i_state.full_pending) begin
                s.prefix_seen  = 1'b1;
                s.full_pending = 1'b0;
                s.all_matched  = 1'b0;
            end else if (i_state.all_matched && i_state.matched < used_len
                         && canon(i_char) == canon(want)) begin
                s.matched = i_state.matched + 1'b1;
                if (s.matched == used_len) begin
                    s.full_pending = 1'b1;
                end
            end else begin
                s.all_matched = 1'b0;
            end
            // end of text closes the current word
            if (!s.found && i_last) begin
                o_res_valid = 1'b1;
                if (s.full_pending) begin
                    o_status     = ST_FOUND;
                    o_word_start = START_BITS'(s.word_start);
                end else if (s.prefix_seen) begin
                    o_status = ST_PREFIX;
                end else begin
                    o_status = ST_NOT_FOUND;
                end
            end
        end
        s.char_pos = next_pos;
        if (i_last) begin
            s = SCAN_RESET;
        end
        o_state = s;
    end

endmodule

`default_nettype wire

FILE: sv/phonetic_word_matcher_core.sv
// Top level of the phonetic word matcher: config registers, scan state,
// output register. Depends on pwm_pkg and pwm_step.
`timescale 1ns / 1ps
`default_nettype none

// Streams text one byte per request and reports, per text, whether a word
// sounding like the configured search word appears. One character is taken
// every cycle; its result, if any, appears on the master side in the cycle after
// acceptance and sits in a single output register, so the slave side stalls
// only while that register holds a result the consumer has not taken. Write
// the search registers only while no text is in flight.
module phonetic_word_matcher_core (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_wr_en,
    input  wire [pwm_pkg::CFG_ADDR_BITS-1:0]     i_cfg_addr,
    input  wire [pwm_pkg::CFG_DATA_BITS-1:0]     i_cfg_wr_data,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire [pwm_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,  // [7:0] text_char
    input  wire                                  s_axis_tlast,  // last_char
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [pwm_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata   // [1:0] status, [17:2] word_start
);
    import pwm_pkg::*;

    logic [SEARCH_BITS-1:0] r_search_chars;
    logic [LENGTH_BITS-1:0] r_search_length;
    t_scan_state            r_state;
    t_scan_state            n_state;
    logic                   r_out_valid;
    logic [STATUS_BITS-1:0] r_status;
    logic [START_BITS-1:0]  r_word_start;
    logic                   res_valid;
    logic [STATUS_BITS-1:0] res_status;
    logic [START_BITS-1:0]  res_start;
    logic                   take;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;

    pwm_step u_step (
        .i_state         (r_state),
        .i_search_chars  (r_search_chars),
        .i_search_length (r_search_length),
        .i_char          (s_axis_tdata[CHAR_BITS-1:0]),
        .i_last          (s_axis_tlast),
        .o_state         (n_state),
        .o_res_valid     (res_valid),
        .o_status        (res_status),
        .o_word_start    (res_start)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_chars  <= '0;
            r_search_length <= LENGTH_BITS'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_SEARCH_CHARS:  r_search_chars  <= i_cfg_wr_data[SEARCH_BITS-1:0];
                REG_SEARCH_LENGTH: r_search_length <= i_cfg_wr_data[LENGTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SCAN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_state <= n_state;
            end
            if (take) begin
                r_out_valid <= res_valid;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && res_valid) begin
            r_status     <= res_status;
            r_word_start <= res_start;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_BITS - START_BITS - STATUS_BITS){1'b0}},
                            r_word_start, r_status};

endmodule

`default_nettype wire

FILE: bench/phonetic_word_matcher_core_test.sv
// Self-checking bench for phonetic_word_matcher_core: directed text table, then
// random texts over several search settings, checked against a local model and typed table values.
// Depends on pwm_pkg and the core.
`timescale 1ns / 1ps

module phonetic_word_matcher_core_test;
    import pwm_pkg::*;

    localparam int          QUIET_LIMIT = 2000;
    localparam logic [63:0] WOOD_WORD   = 64'h0000_0000_646F_6F77;

    typedef struct packed {
        t_status     status;
        logic [15:0] start;
    } t_match;

    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic        load;
        logic        typed;
        t_status     status;
        logic [15:0] start;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [0:0]  i_cfg_addr = '0;
    logic [63:0] i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    phonetic_word_matcher_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] text_char
        .s_axis_tlast  (s_axis_tlast),   // last_char
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [1:0] status, [17:2] word_start
    );

    always #5 i_clk = ~i_clk;

    // directed text; search word is 0x00 (reset) at first, "wood" from row 1
    t_row dir_rows [21] = '{
        '{8'h00, 1'b1, 1'b0, 1'b1, ST_FOUND,     16'd0},
        '{"V",   1'b0, 1'b1, 1'b0, ST_FOUND,     16'd0},
        '{"U",   1'b0, 1'b0, 1'b0, ST_FOUND,     16'd0},
        '{"O",   1'b0, 1'b0, 1'b0, ST_FOUND,     16'd0},
        '{"T",   1'b0, 1'b0, 1'b0, ST_FOUND,     16'd0},
        '{" ",   1'b0, 1'b0, 1'b1, ST_FOUND,     16'd0},
        '{8'hFF, 1'b1, 1'b0, 1'b0, ST_FOUND,     16'd0},
        '{"w",   1'b0, 1'b0, 1'b0, ST_FOUND,     16'd0},
        '{"O",   1'b0, 1'b0, 1'b0, ST_FOUND,     16'd0},
        '{"u",   1'b0, 1'b0, 1'b0, ST_FOUND,     16'd0},
        '{"D",   1'b0, 1'b0, 1'b0, ST_FOUND,     16'd0},
        '{"S",   1'b1, 1'b0, 1'b1, ST_PREFIX,    16'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, ST_FOUND,     16'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, ST_FOUND,     16'd0},
        '{"a",   1'b1, 1'b0, 1'b1, ST_NOT_FOUND, 16'd0},
        '{"x",   1'b0, 1'b0, 1'b0, ST_FOUND,     16'd0},
        '{" ",   1'b0, 1'b0, 1'b0, ST_FOUND,     16'd0},
        '{"W",   1'b0, 1'b0, 1'b0, ST_FOUND,     16'd0},
        '{"u",   1'b0, 1'b0, 1'b0, ST_FOUND,     16'd0},
        '{"o",   1'b0, 1'b0, 1'b0, ST_FOUND,     16'd0},
        '{"t",   1'b1, 1'b0, 1'b1, ST_FOUND,     16'd2}
    };

    // model copy of registers and scan state
    logic [63:0] search_word = '0;
    logic [3:0]  search_len = 4'd1;
    logic [15:0] scan_pos, scan_wstart;
    int          scan_matched;
    bit          scan_all_ok, scan_full, scan_prefix, scan_found;

    t_match want_q[$];
    t_match exp_m;
    int     n_fail, n_chars, n_live, n_texts, n_results, n_settings;
    int     burst_left;
    int     hold_req, hold_seen, hold_left, rx_mode, mode_left;
    int     quiet;

    function automatic logic [7:0] sound_key(input logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
        case (lc)
            "w":          return "v";
            "j":          return "g";
            "z":          return "s";
            "t":          return "d";
            "u":          return "o";
            "y":          return "i";
            "f", "p":     return "b";
            "k", "q":     return "c";
            default:      return lc;
        endcase
    endfunction

    function automatic int used_len();
        if (search_len == 4'd0) return 1;
        if (search_len > 4'd8) return 8;
        return int'(search_len);
    endfunction

    function automatic void next_word(input logic [15:0] s);
        scan_wstart  = s;
        scan_matched = 0;
        scan_all_ok  = 1'b1;
        scan_full    = 1'b0;
    endfunction

    function automatic void clear_scan();
        scan_pos    = '0;
        next_word('0);
        scan_prefix = 1'b0;
        scan_found  = 1'b0;
    endfunction

    function automatic bit scan_step(input logic [7:0] ch, input bit last, output t_match res);
        logic [15:0] nxt;
        bit          got;
        int          n_use;
        got   = 1'b0;
        res   = '{ST_NOT_FOUND, 16'd0};
        n_use = used_len();
        nxt   = (scan_pos == POS_MAX) ? scan_pos : scan_pos + 16'd1;
        if (!scan_found) begin
            if (ch == SPACE_CHAR) begin
                if (scan_full) begin
                    res        = '{ST_FOUND, scan_wstart};
                    scan_found = 1'b1;
                    got        = 1'b1;
                end
                next_word(nxt);
            end else if (scan_full) begin
                scan_prefix = 1'b1;
                scan_full   = 1'b0;
                scan_all_ok = 1'b0;
            end else if (scan_all_ok && scan_matched < n_use &&
                         sound_key(ch) == sound_key(search_word[8*scan_matched +: 8])) begin
                scan_matched++;
                if (scan_matched == n_use) scan_full = 1'b1;
            end else begin
                scan_all_ok = 1'b0;
            end
            if (!scan_found && last) begin
                if (scan_full) res = '{ST_FOUND, scan_wstart};
                else res = '{scan_prefix ? ST_PREFIX : ST_NOT_FOUND, 16'd0};
                got = 1'b1;
                next_word(nxt);
            end
        end
        scan_pos = nxt;
        if (last) clear_scan();
        return got;
    endfunction

    function automatic logic [7:0] pick_alike(input logic [7:0] c);
        logic [7:0] pool[$];
        for (int b = 0; b < 256; b++) begin
            if (sound_key(8'(b)) == sound_key(c)) pool.push_back(8'(b));
        end
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    task automatic offer_char(input logic [7:0] ch, input bit last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk) s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_chars++;
    endtask

    task automatic feed_char(input logic [7:0] ch, input bit last);
        t_match res;
        offer_char(ch, last);
        if (!scan_found) n_live++;
        if (scan_step(ch, last, res)) want_q.push_back(res);
    endtask

    // drop valid and wait until every pending result is out
    task automatic settle();
        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        while (want_q.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= idx;
        i_cfg_wr_data <= val;
        @(negedge i_clk) i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_search(input logic [63:0] chars, input logic [3:0] len);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        settle();
        write_reg(REG_SEARCH_CHARS, chars);
        write_reg(REG_SEARCH_LENGTH, {junk[63:4], len});
        search_word = chars;
        search_len  = len;
        n_settings++;
    endtask

    task automatic send_text();
        logic [7:0] txt[$];
        int         nw, kind, n_use, k, cut;
        n_use = used_len();
        nw    = $urandom_range(1, 5);
        for (int w = 0; w < nw; w++) begin
            if (w > 0 || $urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(0, 4) == 0 ? 2 : 1) txt.push_back(SPACE_CHAR);
            end
            kind = $urandom_range(0, 4);
            case (kind)
                0, 1, 3: begin
                    k = txt.size();
                    for (int c = 0; c < n_use; c++) txt.push_back(pick_alike(search_word[8*c +: 8]));
                    if (kind == 1) begin
                        repeat ($urandom_range(1, 3)) txt.push_back(8'("a" + $urandom_range(0, 25)));
                    end
                    if (kind == 3) txt[k + $urandom_range(0, n_use - 1)] = 8'($urandom_range(0, 255));
                end
                2: begin
                    cut = $urandom_range(0, n_use - 1);
                    for (int c = 0; c < cut; c++) txt.push_back(pick_alike(search_word[8*c +: 8]));
                    if ($urandom_range(0, 1) == 1) txt.push_back(8'("a" + $urandom_range(0, 25)));
                end
                default: begin
                    repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
        if ($urandom_range(0, 4) == 0 || txt.size() == 0) txt.push_back(SPACE_CHAR);
        foreach (txt[i]) feed_char(txt[i], i == txt.size() - 1);
        n_texts++;
    endtask

    function automatic logic [63:0] rand_search();
        logic [63:0] v;
        for (int b = 0; b < 8; b++) begin
            if ($urandom_range(0, 9) < 7)
                v[8*b +: 8] = 8'(($urandom_range(0, 1) ? "A" : "a") + $urandom_range(0, 25));
            else
                v[8*b +: 8] = 8'($urandom_range(0, 255));
        end
        return v;
    endfunction

    // receiver: own stall pattern plus requested long hold-offs
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen     <= hold_req;
            hold_left     <= 100;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= $urandom_range(0, 3);
                mode_left <= $urandom_range(20, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ~m_axis_tready;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (want_q.size() == 0) begin
                $error("result with nothing expected: tdata %h", m_axis_tdata);
                n_fail++;
            end else begin
                exp_m = want_q.pop_front();
                if (m_axis_tdata[1:0] != exp_m.status) begin
                    $error("status: expected %0d, actual %0d", exp_m.status, m_axis_tdata[1:0]);
                    n_fail++;
                end
                if (m_axis_tdata[17:2] != exp_m.start) begin
                    $error("word_start: expected %0d, actual %0d", exp_m.start,
                           m_axis_tdata[17:2]);
                    n_fail++;
                end
                if (m_axis_tdata[23:18] != '0) begin
                    $error("pad: expected 0, actual %h", m_axis_tdata[23:18]);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || i_cfg_wr_en) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        t_match      res;
        bit          got;
        logic [63:0] word_bits;
        logic [3:0]  word_len;
        int          phase;
        clear_scan();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].load) set_search(WOOD_WORD, 4'd4);
            offer_char(dir_rows[r].ch, dir_rows[r].last);
            got = scan_step(dir_rows[r].ch, dir_rows[r].last, res);
            if (dir_rows[r].typed) want_q.push_back('{dir_rows[r].status, dir_rows[r].start});
            else if (got) want_q.push_back(res);
        end

        n_live = 0;
        phase  = 0;
        while (n_chars < 400) begin
            word_bits = rand_search();
            case (phase % 6)
                0:       word_len = 4'd1;
                1:       word_len = 4'd8;
                2:       word_len = 4'd0;
                3:       word_len = 4'($urandom_range(9, 15));
                4: begin
                    word_bits = '1;
                    word_len  = 4'd8;
                end
                default: word_len = 4'($urandom_range(1, 8));
            endcase
            set_search(word_bits, word_len);
            if (phase % 4 == 1) hold_req++;
            repeat (3) begin
                send_text();
                if ($urandom_range(0, 9) == 0) settle();
            end
            phase++;
        end

        settle();
        repeat (8) @(posedge i_clk);
        $display("covered %0d texts and %0d characters (%0d live in the random part) over %0d",
                 n_texts, n_chars, n_live, n_settings);
        $display("search settings, with %0d results checked and %0d mismatches",
                 n_results, n_fail);
        if (n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/pwm_pkg.sv
sv/pwm_step.sv
sv/phonetic_word_matcher_core.sv
bench/phonetic_word_matcher_core_test.sv
